FILE: src/door_sensor_window_debounce_defines.svh
// Assertion macros used by the top-level design file.
`ifndef DOOR_SENSOR_WINDOW_DEBOUNCE_DEFINES_SVH
`define DOOR_SENSOR_WINDOW_DEBOUNCE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DSWD_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dswd assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define DSWD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dswd assertion failed: next-cycle implication");

`endif

FILE: src/dswd_pkg.sv
package dswd_pkg;

  localparam int NUM_BOX   = 3;
  localparam int THR_W     = 7;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [THR_W-1:0]     THR_RESET          = 7'd20;
  localparam logic [REG_IDX_W-1:0] REG_OPEN_THRESHOLD = 1'b0;

  typedef logic [NUM_BOX-1:0] box_vec_t;

  typedef struct packed {
    box_vec_t filtered_state;
    box_vec_t opened_edges;
    box_vec_t closed_edges;
  } result_t;

  // Per-box update handed from the top level to a counter.
  typedef struct packed {
    logic advance;
    logic add;
    logic drop;
  } box_step_t;

endpackage

FILE: src/dswd_if.sv
interface dswd_in_if;
  logic valid;
  logic ready;
  logic box_a_raw;
  logic box_b_raw;
  logic box_c_raw;

  modport source (output valid, output box_a_raw, output box_b_raw, output box_c_raw,
                  input ready);
  modport sink (input valid, input box_a_raw, input box_b_raw, input box_c_raw,
                output ready);
endinterface

interface dswd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] filtered_state;
  logic [2:0] opened_edges;
  logic [2:0] closed_edges;

  modport source (output valid, output filtered_state, output opened_edges,
                  output closed_edges, input ready);
  modport sink (input valid, input filtered_state, input opened_edges,
                input closed_edges, output ready);
endinterface

FILE: src/door_sensor_window_debounce.sv
// Channel   Role    Payload                                          Accepted when
// samples   sink    box_a_raw, box_b_raw, box_c_raw                  valid && ready
// results   source  filtered_state, opened_edges, closed_edges       valid && ready
// apb       slave   open_threshold at byte address 0                 psel && penable && pwrite
//
// One item per cycle while input ready is high; each result is registered in the output
// register, or the skid slot if the output holds; the counters and shift line set its value.
// Reset clears the whole history, counters and previous state together; no sweep.
// A two-entry output buffer parts the sides: input ready drops only when both are full.
`include "door_sensor_window_debounce_defines.svh"

module door_sensor_window_debounce
  import dswd_pkg::*;
#(
  parameter int WINDOW = 32
)
(
  input  logic              clk,
  input  logic              rst,
  dswd_in_if.sink           samples,
  dswd_out_if.source        results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W = $clog2(WINDOW + 1);

  // Configuration register.
  logic [THR_W-1:0]     open_threshold;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_OPEN_THRESHOLD)) begin
      open_threshold <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_OPEN_THRESHOLD) begin
      prdata = DATA_W'(open_threshold);
    end
  end

  // Handshake and the two-entry output buffer.
  logic    accept;
  logic    pop;
  logic    out_valid;
  logic    skid_valid;
  result_t out_q;
  result_t skid_q;
  result_t result_new;

  assign samples.ready = !skid_valid;
  assign accept        = samples.valid && samples.ready;
  assign pop           = out_valid && results.ready;

  // History shift line: tap 0 takes the new sample, the last tap is the oldest in the window.
  box_vec_t taps [WINDOW+1];
  assign taps[0] = {samples.box_c_raw, samples.box_b_raw, samples.box_a_raw};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    dswd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (accept),
      .d       (taps[i]),
      .q       (taps[i+1])
    );
  end

  // One running counter per box: add the newest bit, drop the bit leaving the window.
  box_vec_t filtered;
  box_vec_t last_filtered;

  for (genvar b = 0; b < NUM_BOX; b++) begin : g_box
    box_step_t step;
    assign step = '{advance: accept, add: taps[0][b], drop: taps[WINDOW][b]};

    dswd_box_counter #(.CNT_W(CNT_W)) u_counter (
      .clk       (clk),
      .rst       (rst),
      .step      (step),
      .threshold (open_threshold),
      .is_open   (filtered[b])
    );
  end

  assign result_new = '{filtered_state: filtered,
                        opened_edges:   filtered & ~last_filtered,
                        closed_edges:   ~filtered & last_filtered};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_filtered <= '0;
    end else if (accept) begin
      last_filtered <= filtered;
    end
  end

  // Fill the output register first; park an item in the skid slot only when the output holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_q <= result_new;
      end else begin
        out_q <= result_new;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.filtered_state = out_q.filtered_state;
  assign results.opened_edges   = out_q.opened_edges;
  assign results.closed_edges   = out_q.closed_edges;

  // The skid slot is used only behind a held output.
  `DSWD_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // An item taken into an empty buffer shows at the output next cycle.
  `DSWD_ASSERT_NEXT(a_accept_shows, clk, rst, accept && !out_valid, out_valid)
  // A box cannot open and close on the same item.
  `DSWD_ASSERT_IMPLY(a_edges_disjoint, clk, rst, results.valid,
                     (results.opened_edges & results.closed_edges) == '0)
  // An open edge means the box is now filtered open.
  `DSWD_ASSERT_IMPLY(a_open_edge_state, clk, rst, results.valid,
                     (results.opened_edges & ~results.filtered_state) == '0)

endmodule

FILE: src/dswd_cell.sv
module dswd_cell
  import dswd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  box_vec_t d,
  output box_vec_t q
);

  box_vec_t sample;

  // Shift one slot toward the old end on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (advance) begin
      sample <= d;
    end
  end

  assign q = sample;

endmodule

FILE: src/dswd_box_counter.sv
module dswd_box_counter
  import dswd_pkg::*;
#(
  parameter int CNT_W = 6
)
(
  input  logic             clk,
  input  logic             rst,
  input  box_step_t        step,
  input  logic [THR_W-1:0] threshold,
  output logic             is_open
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] kept;

  always_comb begin
    kept = (count >= CNT_W'(step.drop)) ? count - CNT_W'(step.drop) : count;
    count_next = kept + CNT_W'(step.add);
    is_open = THR_W'(count_next) > threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step.advance) begin
      count <= count_next;
    end
  end

endmodule

FILE: verif/door_sensor_window_debounce_test.sv
`timescale 1ns / 1ps

module door_sensor_window_debounce_test
  import dswd_pkg::*;
;

  // Window depth of the instance; the predictor's history matches it.
  localparam int WINDOW_LEN    = 32;
  localparam int MAX_IDLE      = 19;
  localparam int HOLD_LEN      = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 200;

  // Register 0 sits at byte 0; the next slot up decodes to no register.
  localparam logic [ADDR_W-1:0] THR_ADDR      = {REG_OPEN_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = {~REG_OPEN_THRESHOLD, 2'b00};

  // How one box is driven over a burst of random samples.
  typedef enum int {
    HELD_CLOSED,
    HELD_OPEN,
    NOISY
  } box_drive_e;

  logic clk;
  logic rst;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dswd_in_if  samples_ch ();
  dswd_out_if results_ch ();

  door_sensor_window_debounce #(
    .WINDOW (WINDOW_LEN)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: raw history, per-box open counts, last filtered state,
  // and the threshold as last written over APB.
  box_vec_t         window_hist [WINDOW_LEN];
  int               hist_pos;
  logic [THR_W-1:0] box_count [NUM_BOX];
  box_vec_t         prev_filtered;
  logic [THR_W-1:0] threshold;

  result_t pending_results [$];
  result_t want_result;
  int      fail_count = 0;
  int      result_num = 0;

  // Idling switches, flipped per test phase.
  bit send_idle = 0;
  bit recv_idle = 0;

  // Long receiver hold-off, run by its own process.
  event hold_go;
  logic hold_off = 1'b0;
  int   stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run well past the slowest legal one.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Advance the window by one sample and work out the result it causes.
  function automatic result_t predict_sample(input box_vec_t raw);
    box_vec_t oldest;
    box_vec_t filt;
    result_t  r;
    oldest = window_hist[hist_pos];
    filt   = '0;
    for (int b = 0; b < NUM_BOX; b++) begin
      // drop the sample leaving the window, then add the new one
      if (box_count[b] >= THR_W'(oldest[b]))
        box_count[b] = box_count[b] - THR_W'(oldest[b]);
      box_count[b] = box_count[b] + THR_W'(raw[b]);
      filt[b] = box_count[b] > threshold;
    end
    window_hist[hist_pos] = raw;
    hist_pos = (hist_pos + 1) % WINDOW_LEN;
    r.filtered_state = filt;
    r.opened_edges   = filt & ~prev_filtered;
    r.closed_edges   = ~filt & prev_filtered;
    prev_filtered    = filt;
    return r;
  endfunction

  task automatic report_error(input string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%s", what);
  endtask

  // Offer one sample item, after a random gap if send idling is on; hold valid high across
  // back-to-back items so it never toggles within one time step.
  task automatic send_sample(input box_vec_t raw);
    int      gap;
    result_t predicted;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_ch.valid     <= 1'b1;
    samples_ch.box_a_raw <= raw[0];
    samples_ch.box_b_raw <= raw[1];
    samples_ch.box_c_raw <= raw[2];
    do @(posedge clk); while (!samples_ch.ready);
    // item taken at this edge: queue what it must produce
    predicted       = predict_sample(raw);
    pending_results = {pending_results, predicted};
  endtask

  // Drop valid and wait until every result is back, then wait out the settle time so
  // the block is surely idle.
  task automatic wait_idle();
    samples_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase until pready, then an idle phase.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // only the threshold slot decodes; anything else is dropped
    if (addr[ADDR_W-1:2] == REG_OPEN_THRESHOLD)
      threshold = data[THR_W-1:0];
  endtask

  // Out of reset at the default threshold: A and B read open long enough
  // to cross it and raise their open edges, C toggles and stays closed.
  task automatic test_start_after_reset();
    send_idle = 1;
    recv_idle = 1;
    for (int i = 0; i <= 20; i++)
      send_sample({i[0], 2'b11});
  endtask

  // Threshold of zero: any open sample in the window reports open.
  task automatic test_zero_threshold();
    wait_idle();
    write_reg(THR_ADDR, 32'd0);
    send_sample(3'b111);
    send_sample(3'b000);
    send_sample(3'b100);
  endtask

  // Threshold at or above the window depth: every box reads closed.
  task automatic test_threshold_at_or_above_window();
    wait_idle();
    write_reg(THR_ADDR, 32'(WINDOW_LEN));
    send_sample(3'b111);
    wait_idle();
    write_reg(THR_ADDR, 32'd64);
    send_sample(3'b111);
    wait_idle();
    // upper data bits set: only the low seven land, giving the top value
    write_reg(THR_ADDR, 32'hFFFF_FFFF);
    send_sample(3'b000);
  endtask

  // A write to an unmapped slot must leave the threshold alone.
  task automatic test_unmapped_register();
    wait_idle();
    write_reg(THR_ADDR, 32'd1);
    write_reg(UNMAPPED_ADDR, 32'h7F);
    send_sample(3'b011);
    send_sample(3'b010);
  endtask

  // Hold the result side off for a long stretch while samples keep coming,
  // so the output buffer fills and input ready drops; then drain fully and send eight more.
  task automatic test_output_hold_off();
    wait_idle();
    write_reg(THR_ADDR, 32'd2);
    send_idle = 0;
    recv_idle = 0;
    -> hold_go;
    repeat (24) send_sample(box_vec_t'($urandom_range(0, 7)));
    wait_idle();
    repeat (8) send_sample(box_vec_t'($urandom_range(0, 7)));
  endtask

  // Bursts where each box is held closed, held open, or noisy at a random
  // rate, so the counts sweep across the threshold in both directions.
  task automatic run_random_phase(input int n_items);
    box_drive_e drive [NUM_BOX];
    int         open_pct [NUM_BOX];
    int         sent;
    int         burst_len;
    box_vec_t   raw;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(1, 48);
      for (int b = 0; b < NUM_BOX; b++) begin
        drive[b]    = box_drive_e'($urandom_range(0, 2));
        open_pct[b] = $urandom_range(0, 100);
      end
      for (int k = 0; k < burst_len && sent < n_items; k++) begin
        for (int b = 0; b < NUM_BOX; b++) begin
          case (drive[b])
            HELD_CLOSED: begin
              raw[b] = 1'b0;
            end
            HELD_OPEN: begin
              raw[b] = 1'b1;
            end
            default: begin
              raw[b] = $urandom_range(0, 99) < open_pct[b];
            end
          endcase
        end
        send_sample(raw);
        sent++;
      end
    end
  endtask

  // Walk through thresholds, extremes included, and every idling mix.
  task automatic test_random_windows();
    logic [DATA_W-1:0] thr_list [8];
    thr_list = '{32'd20, 32'd0, 32'd31, 32'd32, 32'd64, 32'd127, 32'd1, 32'd0};
    thr_list[7] = $urandom_range(0, 64);
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_reg(THR_ADDR, thr_list[p]);
      send_idle = p[0];
      recv_idle = p[1];
      run_random_phase(PHASE_ITEMS);
    end
  endtask

  // Receiver hold-off: hold ready low for the HOLD_LEN stretch on request.
  initial begin
    forever begin
      @(hold_go);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (HOLD_LEN) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // Result side: check each accepted item against the oldest expectation,
  // then draw a stall, if receive idling is on, before taking the next one.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_error($sformatf("result %0d with nothing expected: fs=%b oe=%b ce=%b",
                                 result_num, results_ch.filtered_state,
                                 results_ch.opened_edges, results_ch.closed_edges));
        end else begin
          want_result = pending_results.pop_front();
          if (results_ch.filtered_state !== want_result.filtered_state ||
              results_ch.opened_edges !== want_result.opened_edges ||
              results_ch.closed_edges !== want_result.closed_edges)
            report_error($sformatf(
                "result %0d: expected fs=%b oe=%b ce=%b, got fs=%b oe=%b ce=%b",
                result_num, want_result.filtered_state, want_result.opened_edges,
                want_result.closed_edges, results_ch.filtered_state,
                results_ch.opened_edges, results_ch.closed_edges));
        end
        result_num++;
        stall_left = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      results_ch.ready <= (stall_left == 0) && !hold_off;
    end
  end

  initial begin
    int waited;
    // drive every input to a known value before the first edge
    rst                  = 1'b1;
    samples_ch.valid     = 1'b0;
    samples_ch.box_a_raw = 1'b0;
    samples_ch.box_b_raw = 1'b0;
    samples_ch.box_c_raw = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;

    // predictor starts from the reset state: all closed, default threshold
    for (int i = 0; i < WINDOW_LEN; i++)
      window_hist[i] = '0;
    for (int b = 0; b < NUM_BOX; b++)
      box_count[b] = '0;
    hist_pos      = 0;
    prev_filtered = '0;
    threshold     = THR_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_start_after_reset();
    test_zero_threshold();
    test_threshold_at_or_above_window();
    test_unmapped_register();
    test_output_hold_off();
    test_random_windows();

    // drain what is still in flight, bounded, then let late results show
    samples_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d expected results never arrived", pending_results.size()));

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
